[rtl/core/cau_pkg.sv]
// Shared definitions for the complex arithmetic unit: operation codes,
// default word and fraction widths, and the result flag bundle.
// No dependencies; every other file of the unit imports this package.
package cau_pkg;

  localparam int DEFAULT_WORD_BITS     = 32;
  localparam int DEFAULT_FRACTION_BITS = 16;
  localparam int TOL_BITS              = 16;
  localparam int OP_BITS               = 3;

  localparam logic [OP_BITS-1:0] OP_ADD = 3'd0;
  localparam logic [OP_BITS-1:0] OP_SUB = 3'd1;
  localparam logic [OP_BITS-1:0] OP_MUL = 3'd2;
  localparam logic [OP_BITS-1:0] OP_DIV = 3'd3;
  localparam logic [OP_BITS-1:0] OP_NEG = 3'd4;
  localparam logic [OP_BITS-1:0] OP_CMP = 3'd5;

  typedef struct packed {
    logic overflow;
    logic divide_by_zero;
    logic operands_equal;
  } cau_flags_t;

endpackage

[rtl/core/cau_mul.sv]
// Product stages of the complex arithmetic unit: six signed multipliers,
// then the sums that form the complex product, the divide numerator and |b|^2.
// Depends on cau_pkg for the default widths.
module cau_mul
  import cau_pkg::*;
#(
  parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [WORD_BITS-1:0] a_re,
  input  logic signed [WORD_BITS-1:0] a_im,
  input  logic signed [WORD_BITS-1:0] b_re,
  input  logic signed [WORD_BITS-1:0] b_im,
  output logic signed [2*WORD_BITS:0] mul_re,
  output logic signed [2*WORD_BITS:0] mul_im,
  output logic signed [2*WORD_BITS:0] num_re,
  output logic signed [2*WORD_BITS:0] num_im,
  output logic [2*WORD_BITS-1:0]      den
);

  localparam int PW = 2 * WORD_BITS;

  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, sq_r, sq_i;

  // First stage: one multiplier per product.
  always_ff @(posedge clk) begin
    if (en) begin
      p_rr <= a_re * b_re;
      p_ii <= a_im * b_im;
      p_ri <= a_re * b_im;
      p_ir <= a_im * b_re;
      sq_r <= b_re * b_re;
      sq_i <= b_im * b_im;
    end
  end

  // Second stage: exact sums; the squares are never negative.
  always_ff @(posedge clk) begin
    if (en) begin
      mul_re <= (PW+1)'(p_rr) - (PW+1)'(p_ii);
      mul_im <= (PW+1)'(p_ri) + (PW+1)'(p_ir);
      num_re <= (PW+1)'(p_rr) + (PW+1)'(p_ii);
      num_im <= (PW+1)'(p_ir) - (PW+1)'(p_ri);
      den    <= $unsigned(sq_r) + $unsigned(sq_i);
    end
  end

endmodule

[rtl/core/cau_div.sv]
// Pipelined restoring divider for one result part: one quotient bit per stage,
// round to nearest with ties away from zero, then signed saturation.
// Depends on cau_pkg for the default widths.
module cau_div
  import cau_pkg::*;
#(
  parameter int WORD_BITS     = DEFAULT_WORD_BITS,
  parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [2*WORD_BITS-1:0]   mag,
  input  logic                     neg,
  input  logic [2*WORD_BITS-1:0]   den,
  output logic [WORD_BITS-1:0]     quot,
  output logic                     ovf
);

  localparam int PW = 2 * WORD_BITS;
  localparam int SH = WORD_BITS - FRACTION_BITS;
  localparam logic [WORD_BITS-1:0] MAX_V = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] MIN_V = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS:0]   LIM_POS = (WORD_BITS+1)'(MAX_V);
  localparam logic [WORD_BITS:0]   LIM_NEG = (WORD_BITS+1)'(MIN_V);

  logic [PW-1:0]        rem   [0:WORD_BITS];
  logic [PW-1:0]        den_s [0:WORD_BITS];
  logic [WORD_BITS-1:0] q     [0:WORD_BITS];
  logic [WORD_BITS-1:0] nlow  [0:WORD_BITS-1];
  logic                 neg_s [0:WORD_BITS];
  logic                 big_s [0:WORD_BITS];

  // Entry stage: a quotient of 2^WORD_BITS or more saturates in any case,
  // so only WORD_BITS quotient bits remain to be found.
  always_ff @(posedge clk) begin
    if (en) begin
      big_s[0] <= (PW+SH)'(mag) >= ((PW+SH)'(den) << SH);
      rem[0]   <= mag >> SH;
      nlow[0]  <= {mag[SH-1:0], {FRACTION_BITS{1'b0}}};
      q[0]     <= '0;
      den_s[0] <= den;
      neg_s[0] <= neg;
    end
  end

  for (genvar k = 0; k < WORD_BITS; k++) begin : g_step
    logic [PW:0] trial;
    logic        ge;
    assign trial = {rem[k], nlow[k][WORD_BITS-1]};
    assign ge    = trial >= {1'b0, den_s[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]   <= ge ? PW'(trial - {1'b0, den_s[k]}) : trial[PW-1:0];
        q[k+1]     <= {q[k][WORD_BITS-2:0], ge};
        den_s[k+1] <= den_s[k];
        neg_s[k+1] <= neg_s[k];
        big_s[k+1] <= big_s[k];
      end
    end

    if (k < WORD_BITS - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (en) begin
          nlow[k+1] <= nlow[k] << 1;
        end
      end
    end
  end

  logic                 rnd;
  logic [WORD_BITS:0]   qr;
  logic [WORD_BITS:0]   lim;

  assign rnd = {rem[WORD_BITS], 1'b0} >= {1'b0, den_s[WORD_BITS]};
  assign qr  = (WORD_BITS+1)'(q[WORD_BITS]) + (WORD_BITS+1)'(rnd);
  assign lim = neg_s[WORD_BITS] ? LIM_NEG : LIM_POS;

  always_ff @(posedge clk) begin
    if (en) begin
      if (big_s[WORD_BITS] || (qr > lim)) begin
        ovf  <= 1'b1;
        quot <= neg_s[WORD_BITS] ? MIN_V : MAX_V;
      end else begin
        ovf  <= 1'b0;
        quot <= neg_s[WORD_BITS] ? WORD_BITS'(-qr) : qr[WORD_BITS-1:0];
      end
    end
  end

endmodule

[rtl/core/complex_arithmetic_unit.sv]
// Top level of the complex arithmetic unit: input stage, simple operations,
// multiply rounding, divide set-up and the result delay line.
// Depends on cau_pkg, cau_mul and cau_div.
//
//  Channel  | Direction | Handshake         | Payload
//  ---------+-----------+-------------------+--------------------------------------
//  s_       | in        | s_tvalid/s_tready | tdata a_re,a_im,b_re,b_im; tuser op
//  m_       | out       | m_tvalid/m_tready | tdata result_re,result_im; tuser flags
//  cfg_     | in        | cfg_we            | cfg_wdata compare_tolerance
//
// One transaction enters per cycle while the pipeline is not held. The pipeline
// depth is set by the divider, which resolves one quotient bit per pipeline
// stage.
// Reset clears the valid bits of every stage and the tolerance register.
// The whole pipeline advances together; it holds only while a result waits
// at the output and m_tready is low, so no transaction is lost or repeated.
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int WORD_BITS     = DEFAULT_WORD_BITS,
  parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
  input  logic clk,
  input  logic rst,
  // a_re, a_im, b_re, b_im from the lowest bit up, zero padded to bytes
  input  logic [((4*WORD_BITS+7)/8)*8-1:0] s_tdata,
  // operation
  input  logic [OP_BITS-1:0]               s_tuser,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // result_re, result_im from the lowest bit up, zero padded to bytes
  output logic [((2*WORD_BITS+7)/8)*8-1:0] m_tdata,
  // operands_equal, divide_by_zero, overflow from the lowest bit up
  output logic [2:0]                       m_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic                             cfg_we,
  input  logic [TOL_BITS-1:0]              cfg_wdata
);

  localparam int W        = WORD_BITS;
  localparam int PW       = 2 * WORD_BITS;
  localparam int DIV_LAT  = WORD_BITS + 2;
  localparam int NS       = 4 + DIV_LAT;
  localparam int OUT_BITS = ((2*WORD_BITS+7)/8)*8;
  localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [PW+1:0] HALF = (PW+2)'(1) << (FRACTION_BITS - 1);

  // Saturate a value one bit wider than the word; the top bit of the
  // return value is the overflow flag.
  function automatic logic [W:0] sat_narrow(input logic [W:0] x);
    if (x[W] != x[W-1]) begin
      return {1'b1, x[W] ? MIN_V : MAX_V};
    end
    return {1'b0, x[W-1:0]};
  endfunction

  // Round a full product to the word, ties away from zero, then saturate.
  function automatic logic [W:0] round_sat(input logic signed [PW:0] x);
    logic signed [PW+1:0] y;
    logic [PW+2-W:0]      hi;
    y  = ((PW+2)'(x) + (x[PW] ? (HALF - (PW+2)'(1)) : HALF)) >>> FRACTION_BITS;
    hi = y[PW+1:W-1];
    if ((&hi) || !(|hi)) begin
      return {1'b0, y[W-1:0]};
    end
    return {1'b1, y[PW+1] ? MIN_V : MAX_V};
  endfunction

  // Pipeline control: one enable for every stage.
  logic          en;
  logic [NS-1:0] v;

  assign en       = !v[NS-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NS-2:0], s_tvalid};
    end
  end

  logic [TOL_BITS-1:0] tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0;
    end else if (cfg_we) begin
      tol <= cfg_wdata;
    end
  end

  // Stage 1: capture the transaction.
  logic [OP_BITS-1:0]  op1;
  logic signed [W-1:0] ar1, ai1, br1, bi1;

  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= s_tuser;
      ar1 <= s_tdata[W-1:0];
      ai1 <= s_tdata[2*W-1:W];
      br1 <= s_tdata[3*W-1:2*W];
      bi1 <= s_tdata[4*W-1:3*W];
    end
  end

  // Stage 2: add, subtract, negate and compare finish here, while the
  // multipliers work on the same operands.
  logic [W:0]          sum_re, sum_im;
  logic signed [W:0]   d_re, d_im, ad_re, ad_im;
  logic [W:0]          simple_re, simple_im;
  logic                cmp_eq;

  assign d_re  = (W+1)'(ar1) - (W+1)'(br1);
  assign d_im  = (W+1)'(ai1) - (W+1)'(bi1);
  assign ad_re = d_re[W] ? -d_re : d_re;
  assign ad_im = d_im[W] ? -d_im : d_im;
  assign cmp_eq = ($unsigned(ad_re) <= (W+1)'(tol)) && ($unsigned(ad_im) <= (W+1)'(tol));

  always_comb begin
    sum_re    = (W+1)'(ar1) + (W+1)'(br1);
    sum_im    = (W+1)'(ai1) + (W+1)'(bi1);
    simple_re = '0;
    simple_im = '0;
    case (op1)
      OP_ADD: begin
        simple_re = sat_narrow(sum_re);
        simple_im = sat_narrow(sum_im);
      end
      OP_SUB: begin
        simple_re = sat_narrow(d_re);
        simple_im = sat_narrow(d_im);
      end
      OP_NEG: begin
        simple_re = sat_narrow(-(W+1)'(ar1));
        simple_im = sat_narrow(-(W+1)'(ai1));
      end
      default: begin
        simple_re = '0;
        simple_im = '0;
      end
    endcase
  end

  logic [OP_BITS-1:0] op2, op3;
  logic [W-1:0]       re2, im2, re3, im3;
  cau_flags_t         fl2, fl3;

  always_ff @(posedge clk) begin
    if (en) begin
      op2                <= op1;
      re2                <= simple_re[W-1:0];
      im2                <= simple_im[W-1:0];
      fl2.overflow       <= simple_re[W] || simple_im[W];
      fl2.divide_by_zero <= 1'b0;
      fl2.operands_equal <= (op1 == OP_CMP) && cmp_eq;
    end
  end

  // Stage 3: carry the simple results beside the product sums.
  always_ff @(posedge clk) begin
    if (en) begin
      op3 <= op2;
      re3 <= re2;
      im3 <= im2;
      fl3 <= fl2;
    end
  end

  logic signed [PW:0] mul_re, mul_im, num_re, num_im;
  logic [PW-1:0]      den;

  cau_mul #(
    .WORD_BITS (WORD_BITS)
  ) u_mul (
    .clk    (clk),
    .en     (en),
    .a_re   (ar1),
    .a_im   (ai1),
    .b_re   (br1),
    .b_im   (bi1),
    .mul_re (mul_re),
    .mul_im (mul_im),
    .num_re (num_re),
    .num_im (num_im),
    .den    (den)
  );

  // Stage 4: finish multiply, prepare divide magnitudes and detect a zero
  // denominator. Its registers open the delay line that runs beside the divider.
  logic [W:0]         rs_re, rs_im;
  logic [PW-1:0]      mag_re, mag_im, den4;
  logic               neg_re, neg_im;

  assign rs_re = round_sat(mul_re);
  assign rs_im = round_sat(mul_im);

  logic [W-1:0]       side_re  [0:DIV_LAT];
  logic [W-1:0]       side_im  [0:DIV_LAT];
  cau_flags_t         side_fl  [0:DIV_LAT];
  logic               side_div [0:DIV_LAT];
  logic               side_dz  [0:DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      mag_re <= num_re[PW] ? PW'(-num_re) : num_re[PW-1:0];
      mag_im <= num_im[PW] ? PW'(-num_im) : num_im[PW-1:0];
      neg_re <= num_re[PW];
      neg_im <= num_im[PW];
      den4   <= den;
      side_div[0] <= (op3 == OP_DIV);
      side_dz[0]  <= (den == '0);
      if (op3 == OP_MUL) begin
        side_re[0]                <= rs_re[W-1:0];
        side_im[0]                <= rs_im[W-1:0];
        side_fl[0].overflow       <= rs_re[W] || rs_im[W];
        side_fl[0].divide_by_zero <= 1'b0;
        side_fl[0].operands_equal <= 1'b0;
      end else begin
        side_re[0] <= re3;
        side_im[0] <= im3;
        side_fl[0] <= fl3;
      end
    end
  end

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        side_re[k+1]  <= side_re[k];
        side_im[k+1]  <= side_im[k];
        side_fl[k+1]  <= side_fl[k];
        side_div[k+1] <= side_div[k];
        side_dz[k+1]  <= side_dz[k];
      end
    end
  end

  logic [W-1:0] q_re, q_im;
  logic         q_ovf_re, q_ovf_im;

  cau_div #(
    .WORD_BITS     (WORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div_re (
    .clk  (clk),
    .en   (en),
    .mag  (mag_re),
    .neg  (neg_re),
    .den  (den4),
    .quot (q_re),
    .ovf  (q_ovf_re)
  );

  cau_div #(
    .WORD_BITS     (WORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div_im (
    .clk  (clk),
    .en   (en),
    .mag  (mag_im),
    .neg  (neg_im),
    .den  (den4),
    .quot (q_im),
    .ovf  (q_ovf_im)
  );

  // Output selection from registers only. A divide by a zero denominator reports the
  // largest positive value in both parts and no overflow.
  logic [W-1:0] out_re, out_im;
  cau_flags_t   out_fl;

  always_comb begin
    out_re = side_re[DIV_LAT];
    out_im = side_im[DIV_LAT];
    out_fl = side_fl[DIV_LAT];
    if (side_div[DIV_LAT]) begin
      if (side_dz[DIV_LAT]) begin
        out_re                = MAX_V;
        out_im                = MAX_V;
        out_fl.overflow       = 1'b0;
        out_fl.divide_by_zero = 1'b1;
        out_fl.operands_equal = 1'b0;
      end else begin
        out_re                = q_re;
        out_im                = q_im;
        out_fl.overflow       = q_ovf_re || q_ovf_im;
        out_fl.divide_by_zero = 1'b0;
        out_fl.operands_equal = 1'b0;
      end
    end
  end

  assign m_tdata = OUT_BITS'({out_im, out_re});
  assign m_tuser = out_fl;

  // A zero denominator result is the positive limit in both parts.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_fl.divide_by_zero |->
      out_re == MAX_V && out_im == MAX_V && !out_fl.overflow)
    else $error("divide by zero result malformed");

  // Results that report equal operands carry a zero value and never a status flag.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_fl.operands_equal |->
      out_re == '0 && out_im == '0 && !out_fl.overflow && !out_fl.divide_by_zero)
    else $error("compare result carries data or status");

  // An accepted transaction occupies the first stage on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v[0])
    else $error("accepted transaction missing from first stage");

endmodule
